/* src/assert_macros.svh */
// Assertion helpers for the RTL files; clp_parser includes them.
// CLP_ASSERT is sampled on the clock and switched off while reset is held.
// CLP_ASSERT_ANY is sampled on the clock at every edge, reset or not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CLP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");

`define CLP_ASSERT_ANY(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("%m: assertion failed");

`endif

/* src/clp_pkg.sv */
`timescale 1ns / 1ps

package clp_pkg;

  // Characters that the parser recognises.
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_EQUALS = 8'h3D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_Z      = 8'h5A;

  // Command letters as held in the seven bit opcode.
  localparam logic [6:0] OP_A = 7'h41;
  localparam logic [6:0] OP_B = 7'h42;
  localparam logic [6:0] OP_C = 7'h43;
  localparam logic [6:0] OP_E = 7'h45;
  localparam logic [6:0] OP_O = 7'h4F;
  localparam logic [6:0] OP_R = 7'h52;
  localparam logic [6:0] OP_S = 7'h53;
  localparam logic [6:0] OP_T = 7'h54;
  localparam logic [6:0] OP_U = 7'h55;
  localparam logic [6:0] OP_V = 7'h56;
  localparam logic [6:0] OP_W = 7'h57;
  localparam logic [6:0] OP_Z = 7'h5A;

  // Index limits of the indexed commands.
  localparam logic [7:0] ChannelMax  = 8'd8;
  localparam logic [7:0] EepromItems = 8'd16;
  localparam logic [7:0] UsbPorts    = 8'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNKNOWN   = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_NO_SET    = 2'd3
  } clp_status_e;

  // One received byte waiting in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } clp_byte_t;

  // One decoded command.
  typedef struct packed {
    logic [6:0]  opcode;
    logic [7:0]  entry_index;
    logic        is_write;
    logic [31:0] write_value;
    clp_status_e status;
  } clp_cmd_t;

endpackage

/* src/clp_if.sv */
`timescale 1ns / 1ps

// Received byte channel.
interface clp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Decoded command channel.
interface clp_cmd_if;
  logic        valid;
  logic        ready;
  logic [6:0]  opcode;
  logic [7:0]  entry_index;
  logic        is_write;
  logic [31:0] write_value;
  logic [1:0]  status;

  modport source (
    output valid, output opcode, output entry_index, output is_write,
    output write_value, output status, input ready
  );
  modport sink (
    input valid, input opcode, input entry_index, input is_write,
    input write_value, input status, output ready
  );
endinterface

/* src/clp_in_stage.sv */
`timescale 1ns / 1ps

module clp_in_stage import clp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  clp_rx_if.sink    rx_i,
  input  logic      take_i,
  output clp_byte_t byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  // The register can be refilled when it is empty or its item leaves now.
  assign rx_i.ready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      valid_q <= rx_i.valid;
    end
  end

  // Payload is only loaded on an accepted item.
  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  assign byte_o.valid   = valid_q;
  assign byte_o.rx_byte = byte_q;

endmodule

/* src/clp_parser.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module clp_parser import clp_pkg::*; #(
  parameter logic [7:0] EepromItems = clp_pkg::EepromItems,
  parameter logic [7:0] UsbPorts    = clp_pkg::UsbPorts
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  clp_byte_t byte_i,
  input  logic      out_free_i,
  output logic      take_o,
  output logic      push_o,
  output clp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_CMD  = 3'd1,
    PH_EQ   = 3'd2,
    PH_DATA = 3'd3,
    PH_WAIT = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [6:0]  opcode_q, opcode_d;
  logic [7:0]  index_q, index_d;
  logic        write_q, write_d;
  logic [31:0] value_q, value_d;

  logic        is_cr;
  logic        is_eq;
  logic        is_digit;
  logic        is_letter;
  logic [3:0]  digit;
  logic [7:0]  index_next;
  logic [31:0] value_next;
  logic        emit;
  clp_status_e status;

  // Character classes of the byte in the input register.
  assign is_cr     = (byte_i.rx_byte == CHAR_CR);
  assign is_eq     = (byte_i.rx_byte == CHAR_EQUALS);
  assign is_digit  = (byte_i.rx_byte >= CHAR_ZERO) && (byte_i.rx_byte <= CHAR_NINE);
  assign is_letter = (byte_i.rx_byte >= CHAR_A) && (byte_i.rx_byte <= CHAR_Z);
  assign digit     = 4'(byte_i.rx_byte - CHAR_ZERO);

  // Decimal accumulation as x*8 + x*2 + digit, wrapping at the register width.
  assign index_next = {index_q[4:0], 3'b000} + {index_q[6:0], 1'b0} + {4'b0000, digit};
  assign value_next = {value_q[28:0], 3'b000} + {value_q[30:0], 1'b0} + {28'd0, digit};

  // Next state of the parser for the current byte.
  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    index_d  = index_q;
    write_d  = write_q;
    value_d  = value_q;
    emit     = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (is_letter) begin
          opcode_d = byte_i.rx_byte[6:0];
          index_d  = '0;
          write_d  = 1'b0;
          value_d  = '0;
          phase_d  = PH_CMD;
        end
      end
      PH_CMD: begin
        if (is_cr) begin
          emit    = 1'b1;
          phase_d = PH_IDLE;
        end else if (is_eq) begin
          write_d = 1'b1;
          phase_d = PH_EQ;
        end else if (is_digit) begin
          index_d = index_next;
        end
      end
      PH_EQ: begin
        if (is_cr) begin
          emit    = 1'b1;
          phase_d = PH_IDLE;
        end else if (is_digit) begin
          value_d = {28'd0, digit};
          phase_d = PH_DATA;
        end else begin
          phase_d = PH_WAIT;
        end
      end
      PH_DATA: begin
        if (is_cr) begin
          emit    = 1'b1;
          phase_d = PH_IDLE;
        end else if (is_digit) begin
          value_d = value_next;
        end else begin
          phase_d = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (is_cr) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Status of the held command by its letter.
  always_comb begin
    unique case (opcode_q) inside
      OP_A: begin
        if (write_q) begin
          status = ST_NO_SET;
        end else begin
          status = (index_q == 8'd1) ? ST_OK : ST_BAD_INDEX;
        end
      end
      OP_B, OP_S, OP_V: begin
        status = write_q ? ST_NO_SET : ST_OK;
      end
      OP_C: begin
        status = (index_q <= ChannelMax) ? ST_OK : ST_BAD_INDEX;
      end
      OP_E: begin
        status = (index_q < EepromItems) ? ST_OK : ST_BAD_INDEX;
      end
      OP_U: begin
        status = (index_q >= 8'd1 && index_q <= UsbPorts) ? ST_OK : ST_BAD_INDEX;
      end
      OP_O, OP_R, OP_T, OP_W: begin
        status = ST_OK;
      end
      default: begin
        status = ST_UNKNOWN;
      end
    endcase
  end

  // A byte that ends a command waits until the result register has room.
  assign take_o = byte_i.valid && (!emit || out_free_i);
  assign push_o = byte_i.valid && emit && out_free_i;

  // Parser state advances once per consumed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      opcode_q <= '0;
      index_q  <= '0;
      write_q  <= 1'b0;
      value_q  <= '0;
    end else if (take_o) begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      index_q  <= index_d;
      write_q  <= write_d;
      value_q  <= value_d;
    end
  end

  assign cmd_o.opcode      = opcode_q;
  assign cmd_o.entry_index = index_q;
  assign cmd_o.is_write    = write_q;
  assign cmd_o.write_value = value_q;
  assign cmd_o.status      = status;

  // A command only leaves from one of the line phases.
  `CLP_ASSERT(a_emit_phase, emit |-> (phase_q == PH_CMD || phase_q == PH_EQ || phase_q == PH_DATA))
  // Every emitted command carries a capital letter.
  `CLP_ASSERT(a_push_letter, push_o |-> (cmd_o.opcode >= OP_A && cmd_o.opcode <= OP_Z))
  // After a command is pushed the parser is back at the start of a line.
  `CLP_ASSERT(a_push_idle, push_o |=> (phase_q == PH_IDLE))
  // A stalled byte leaves the parser state untouched.
  `CLP_ASSERT(a_stall_hold, (byte_i.valid && !take_o) |=> ($stable(phase_q) && $stable(value_q)))
  // A push never overwrites a result that is still waiting.
  `CLP_ASSERT_ANY(a_push_room, push_o |-> out_free_i)

endmodule

/* src/clp_out_stage.sv */
`timescale 1ns / 1ps

module clp_out_stage import clp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  clp_cmd_t  cmd_i,
  output logic      out_free_o,
  clp_cmd_if.source cmd_o
);

  logic     valid_q;
  clp_cmd_t cmd_q;

  // Room for a new result when empty or when the waiting one is taken now.
  assign out_free_o = !valid_q || cmd_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      cmd_q <= cmd_i;
    end
  end

  assign cmd_o.valid       = valid_q;
  assign cmd_o.opcode      = cmd_q.opcode;
  assign cmd_o.entry_index = cmd_q.entry_index;
  assign cmd_o.is_write    = cmd_q.is_write;
  assign cmd_o.write_value = cmd_q.write_value;
  assign cmd_o.status      = cmd_q.status;

endmodule

/* src/ascii_command_line_parser_top.sv */
`timescale 1ns / 1ps

// Command line parser: takes one received character per item on rx_i and,
// for every line of the form letter, optional decimal index, optional '='
// and decimal value, ended by a carriage return, delivers one decoded command
// with its status on cmd_o; a line whose value is malformed yields nothing.
// The block accepts one character in every cycle while input is not held
// back. A character passes an input register, the parser state update and a
// result register, which takes a command as its carriage return is consumed.
// Input is held back only while a finished command waits in the result
// register and the carriage return of the next command waits in the input
// register.

module ascii_command_line_parser_top import clp_pkg::*; #(
  parameter logic [7:0] EepromItems = clp_pkg::EepromItems,
  parameter logic [7:0] UsbPorts    = clp_pkg::UsbPorts
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  clp_rx_if.sink    rx_i,
  clp_cmd_if.source cmd_o
);

  clp_byte_t byte_w;
  clp_cmd_t  cmd_w;
  logic      take_w;
  logic      push_w;
  logic      out_free_w;

  clp_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .take_i (take_w),
    .byte_o (byte_w)
  );

  clp_parser #(
    .EepromItems (EepromItems),
    .UsbPorts    (UsbPorts)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (byte_w),
    .out_free_i (out_free_w),
    .take_o     (take_w),
    .push_o     (push_w),
    .cmd_o      (cmd_w)
  );

  clp_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_w),
    .cmd_i      (cmd_w),
    .out_free_o (out_free_w),
    .cmd_o      (cmd_o)
  );

endmodule

/* tb/sv/tb_ascii_command_line_parser_top.sv */
`timescale 1ns / 1ps

module tb_ascii_command_line_parser_top;
  import clp_pkg::*;

  // Parser phases as the line is read.
  typedef enum logic [2:0] {
    LINE_IDLE  = 3'd0,
    LINE_HEAD  = 3'd1,
    LINE_EQ    = 3'd2,
    LINE_VALUE = 3'd3,
    LINE_SKIP  = 3'd4
  } line_phase_e;

  // Ways in which the command receiver takes results.
  typedef enum logic [1:0] {
    READY_ALWAYS  = 2'd0,
    READY_PATTERN = 2'd1,
    READY_SPARSE  = 2'd2,
    READY_COIN    = 2'd3
  } ready_mode_e;

  localparam int RandomChars = 1800;
  localparam int MaxReported = 10;

  logic clk;
  logic rst_n;

  clp_rx_if  rx_bus ();
  clp_cmd_if cmd_bus ();

  ascii_command_line_parser_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_bus),
    .cmd_o  (cmd_bus)
  );

  // Characters still to be sent and commands still to be received.
  logic [7:0] char_send_q [$];
  clp_cmd_t   cmd_expect_q [$];

  // Shadow copy of the line being parsed.
  line_phase_e line_phase;
  logic [6:0]  line_op;
  logic [7:0]  line_index;
  logic        line_write;
  logic [31:0] line_value;

  int unsigned error_count;
  int unsigned chars_total;
  int unsigned chars_taken;
  int unsigned cmds_seen;
  int unsigned sets_seen;
  int unsigned status_seen [4];
  bit          rx_took;

  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned ready_left;
  logic [31:0] ready_bits;
  ready_mode_e ready_mode;

  logic [6:0]  op_pool [0:10] = '{OP_A, OP_B, OP_C, OP_E, OP_O, OP_R,
                                  OP_S, OP_T, OP_U, OP_V, OP_W};
  int unsigned index_picks [0:12] = '{0, 1, 2, 3, 7, 8, 9, 15, 16, 17,
                                      255, 256, 300};
  longint unsigned value_picks [0:4] = '{0, 1, 64'd4294967295, 64'd4294967296,
                                         64'd99999999999};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d of %0d characters taken.", chars_taken, chars_total);
    $display("DONE: errors detected");
    $finish;
  end

  // Status of the held command, by its letter, index and set flag.
  function automatic clp_status_e line_status();
    case (line_op)
      OP_A: begin
        if (line_write) return ST_NO_SET;
        return (line_index == 8'd1) ? ST_OK : ST_BAD_INDEX;
      end
      OP_B, OP_S, OP_V: return line_write ? ST_NO_SET : ST_OK;
      OP_C: return (line_index <= ChannelMax) ? ST_OK : ST_BAD_INDEX;
      OP_E: return (line_index < EepromItems) ? ST_OK : ST_BAD_INDEX;
      OP_U: return (line_index >= 8'd1 && line_index <= UsbPorts) ? ST_OK : ST_BAD_INDEX;
      OP_O, OP_R, OP_T, OP_W: return ST_OK;
      default: return ST_UNKNOWN;
    endcase
  endfunction

  function automatic void finish_line();
    clp_cmd_t done_cmd;
    done_cmd.opcode      = line_op;
    done_cmd.entry_index = line_index;
    done_cmd.is_write    = line_write;
    done_cmd.write_value = line_value;
    done_cmd.status      = line_status();
    cmd_expect_q.push_back(done_cmd);
    line_phase = LINE_IDLE;
  endfunction

  // Advances the shadow parser by one character.
  function automatic void parse_char(input logic [7:0] c);
    bit is_digit;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    case (line_phase)
      LINE_IDLE: begin
        if (c >= CHAR_A && c <= CHAR_Z) begin
          line_op    = c[6:0];
          line_index = 8'd0;
          line_write = 1'b0;
          line_value = 32'd0;
          line_phase = LINE_HEAD;
        end
      end
      LINE_HEAD: begin
        if (c == CHAR_CR) begin
          finish_line();
        end else if (c == CHAR_EQUALS) begin
          line_write = 1'b1;
          line_phase = LINE_EQ;
        end else if (is_digit) begin
          line_index = line_index * 8'd10 + (c - CHAR_ZERO);
        end
      end
      LINE_EQ: begin
        if (c == CHAR_CR) begin
          finish_line();
        end else if (is_digit) begin
          line_value = 32'(c - CHAR_ZERO);
          line_phase = LINE_VALUE;
        end else begin
          line_phase = LINE_SKIP;
        end
      end
      LINE_VALUE: begin
        if (c == CHAR_CR) begin
          finish_line();
        end else if (is_digit) begin
          line_value = line_value * 32'd10 + 32'(c - CHAR_ZERO);
        end else begin
          line_phase = LINE_SKIP;
        end
      end
      LINE_SKIP: begin
        if (c == CHAR_CR) line_phase = LINE_IDLE;
      end
      default: line_phase = LINE_IDLE;
    endcase
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= MaxReported) $display("ERROR at %0t ns: %s", $realtime, msg);
  endfunction

  // Compares one delivered command with the oldest one predicted.
  function automatic void check_command();
    clp_cmd_t want;
    if (cmd_expect_q.size() == 0) begin
      note_error($sformatf("unexpected command op=%h index=%0d set=%0d value=%0d status=%0d",
                           cmd_bus.opcode, cmd_bus.entry_index, cmd_bus.is_write,
                           cmd_bus.write_value, cmd_bus.status));
      return;
    end
    want = cmd_expect_q.pop_front();
    cmds_seen++;
    status_seen[want.status]++;
    if (want.is_write) sets_seen++;
    if (cmd_bus.opcode !== want.opcode || cmd_bus.entry_index !== want.entry_index ||
        cmd_bus.is_write !== want.is_write || cmd_bus.write_value !== want.write_value ||
        cmd_bus.status !== want.status) begin
      note_error($sformatf({"command %0d: expected op=%h index=%0d set=%0d value=%0d ",
                            "status=%0d, got op=%h index=%0d set=%0d value=%0d status=%0d"},
                           cmds_seen, want.opcode, want.entry_index, want.is_write,
                           want.write_value, want.status, cmd_bus.opcode,
                           cmd_bus.entry_index, cmd_bus.is_write, cmd_bus.write_value,
                           cmd_bus.status));
    end
  endfunction

  // Both channels are observed at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      rx_took = rx_bus.valid && rx_bus.ready;
      if (rx_took) begin
        parse_char(rx_bus.rx_byte);
        chars_taken++;
      end
      if (cmd_bus.valid && cmd_bus.ready) check_command();
    end else begin
      rx_took = 1'b0;
    end
  end

  // Character sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst_n && (!rx_bus.valid || rx_took)) begin
      if (gap_left > 0) begin
        rx_bus.valid <= 1'b0;
        gap_left--;
      end else if (char_send_q.size() > 0) begin
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= char_send_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        rx_bus.valid <= 1'b0;
      end
    end
  end

  // Command receiver: the stall mode is drawn anew whenever its run ends.
  always @(negedge clk) begin
    if (rst_n) begin
      if (ready_left == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 3));
        ready_left = $urandom_range(20, 120);
        ready_bits = $urandom;
      end
      ready_left--;
      case (ready_mode)
        READY_ALWAYS:  cmd_bus.ready <= 1'b1;
        READY_PATTERN: cmd_bus.ready <= ready_bits[ready_left % 32];
        READY_SPARSE:  cmd_bus.ready <= ($urandom_range(0, 7) == 0);
        default:       cmd_bus.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  task automatic push_text(input string s);
    for (int k = 0; k < s.len(); k++) char_send_q.push_back(s[k]);
  endtask

  task automatic push_line(input string s);
    push_text(s);
    char_send_q.push_back(CHAR_CR);
  endtask

  task automatic push_digits(input int unsigned n);
    repeat (n) char_send_q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
  endtask

  // Any character that is neither a digit, an equals sign nor a carriage return.
  function automatic logic [7:0] pick_junk();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CHAR_CR || c == CHAR_EQUALS || (c >= CHAR_ZERO && c <= CHAR_NINE));
    return c;
  endfunction

  // One random line: mostly well formed, some malformed, some loose noise.
  task automatic push_random_line();
    int unsigned kind;
    bit          broken;
    kind   = $urandom_range(0, 99);
    broken = (kind >= 88);
    if (kind < 8) begin
      repeat ($urandom_range(1, 6)) char_send_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0) char_send_q.push_back(8'(CHAR_A + $urandom_range(0, 25)));
    else char_send_q.push_back({1'b0, op_pool[$urandom_range(0, 10)]});
    case ($urandom_range(0, 3))
      0: ;
      1: push_text($sformatf("%0d", index_picks[$urandom_range(0, 12)]));
      default: begin
        if ($urandom_range(0, 4) == 0) char_send_q.push_back(CHAR_ZERO);
        push_digits($urandom_range(1, 5));
      end
    endcase
    if ($urandom_range(0, 9) == 0) char_send_q.push_back(pick_junk());
    if (broken || $urandom_range(0, 1) == 1) begin
      char_send_q.push_back(CHAR_EQUALS);
      case ($urandom_range(0, 3))
        0: ;
        1: push_text($sformatf("%0d", value_picks[$urandom_range(0, 4)]));
        default: push_digits($urandom_range(1, 12));
      endcase
      // A malformed value: a stray character, then anything up to the terminator.
      if (broken) begin
        char_send_q.push_back(($urandom_range(0, 2) == 0) ? CHAR_EQUALS : pick_junk());
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 1) == 1) push_digits(1);
          else char_send_q.push_back(pick_junk());
        end
      end
    end
    char_send_q.push_back(CHAR_CR);
  endtask

  initial begin
    rst_n          = 1'b0;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = 8'd0;
    cmd_bus.ready  = 1'b0;
    line_phase     = LINE_IDLE;
    line_op        = 7'd0;
    line_index     = 8'd0;
    line_write     = 1'b0;
    line_value     = 32'd0;
    error_count    = 0;
    chars_taken    = 0;
    cmds_seen      = 0;
    sets_seen      = 0;
    status_seen    = '{default: 0};
    rx_took        = 1'b0;
    burst_left     = 0;
    gap_left       = 0;
    ready_left     = 0;

    // Directed lines: ignored characters while idle, an ignored character in
    // the index, an equals sign with no value, a second equals sign, a letter
    // in the value and an unknown letter with the largest index.
    char_send_q.push_back(CHAR_CR);
    char_send_q.push_back(8'h00);
    char_send_q.push_back(8'hFF);
    push_line("A1");
    push_line("U3x=");
    push_line("B=1=");
    push_line("S=9a");
    push_line("Z255");

    while (char_send_q.size() < 26 + RandomChars) push_random_line();
    chars_total = char_send_q.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Drain: every character taken, every command delivered, then a short tail.
    do @(negedge clk); while (chars_taken < chars_total);
    do @(negedge clk); while (cmd_expect_q.size() > 0);
    repeat (20) @(negedge clk);

    $display("Sent %0d characters; checked %0d commands, %0d of them sets.",
             chars_taken, cmds_seen, sets_seen);
    $display("Statuses ok/unknown/bad index/no set: %0d/%0d/%0d/%0d; mismatches: %0d.",
             status_seen[ST_OK], status_seen[ST_UNKNOWN], status_seen[ST_BAD_INDEX],
             status_seen[ST_NO_SET], error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
